/* sv/cdq_pkg.sv */
package cdq_pkg;

  localparam int unsigned DEPTH_DEF = 1024;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned CMD_W     = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 2'd0,
    CMD_POP_FRONT  = 2'd1,
    CMD_PUSH_BACK  = 2'd2,
    CMD_POP_BACK   = 2'd3
  } cdq_cmd_t;

  // Per-operation status, carried from the pointer logic to the result stage
  typedef struct packed {
    logic rd;       // entry read from the ring, value due next cycle
    logic empty;    // pop found nothing
    logic dropped;  // push on a full ring discarded an element
  } cdq_res_t;

endpackage

/* sv/cdq_ram.sv */
module cdq_ram #(
  parameter int unsigned DEPTH = cdq_pkg::DEPTH_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [AW-1:0]             waddr,
  input  logic [cdq_pkg::DATA_W-1:0] wdata,
  input  logic                      re,
  input  logic [AW-1:0]             raddr,
  output logic [cdq_pkg::DATA_W-1:0] rdata
);
  import cdq_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* sv/cdq_ctrl.sv */
module cdq_ctrl #(
  parameter int unsigned DEPTH = cdq_pkg::DEPTH_DEF,
  parameter int unsigned AW    = $clog2(DEPTH),
  parameter int unsigned CW    = $clog2(DEPTH + 1)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       step,
  input  cdq_pkg::cdq_cmd_t          cmd,
  input  logic [cdq_pkg::DATA_W-1:0] push_value,
  output logic                       ram_we,
  output logic [AW-1:0]              ram_waddr,
  output logic [cdq_pkg::DATA_W-1:0] ram_wdata,
  output logic                       ram_re,
  output logic [AW-1:0]              ram_raddr,
  output cdq_pkg::cdq_res_t          res,
  output logic [CW-1:0]              count_nxt
);
  import cdq_pkg::*;

  localparam logic [AW-1:0] IDX_LAST = AW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  logic [AW-1:0] front_r, front_nxt;
  logic [AW-1:0] back_r, back_nxt;
  logic [CW-1:0] count_r;
  logic [AW-1:0] front_inc, front_dec, back_inc, back_dec;
  logic          full, empty;

  assign front_inc = (front_r == IDX_LAST) ? '0 : front_r + 1'b1;
  assign front_dec = (front_r == '0) ? IDX_LAST : front_r - 1'b1;
  assign back_inc  = (back_r == IDX_LAST) ? '0 : back_r + 1'b1;
  assign back_dec  = (back_r == '0) ? IDX_LAST : back_r - 1'b1;
  assign full      = (count_r == CNT_FULL);
  assign empty     = (count_r == '0);
  assign ram_wdata = push_value;

  always_comb begin
    front_nxt   = front_r;
    back_nxt    = back_r;
    count_nxt   = count_r;
    ram_we      = 1'b0;
    ram_waddr   = back_r;
    ram_re      = 1'b0;
    ram_raddr   = front_r;
    res         = '0;
    unique case (cmd)
      CMD_PUSH_FRONT: begin
        front_nxt = front_dec;
        ram_we    = step;
        ram_waddr = front_dec;
        if (full) begin
          back_nxt    = back_dec;
          res.dropped = 1'b1;
        end else begin
          count_nxt = count_r + 1'b1;
        end
      end
      CMD_POP_FRONT: begin
        if (empty) begin
          res.empty = 1'b1;
        end else begin
          ram_re    = step;
          ram_raddr = front_r;
          res.rd    = 1'b1;
          front_nxt = front_inc;
          count_nxt = count_r - 1'b1;
        end
      end
      CMD_PUSH_BACK: begin
        ram_we    = step;
        ram_waddr = back_r;
        back_nxt  = back_inc;
        if (full) begin
          front_nxt   = front_inc;
          res.dropped = 1'b1;
        end else begin
          count_nxt = count_r + 1'b1;
        end
      end
      CMD_POP_BACK: begin
        if (empty) begin
          res.empty = 1'b1;
        end else begin
          back_nxt  = back_dec;
          ram_re    = step;
          ram_raddr = back_dec;
          res.rd    = 1'b1;
          count_nxt = count_r - 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
      back_r  <= '0;
      count_r <= '0;
    end else if (step) begin
      front_r <= front_nxt;
      back_r  <= back_nxt;
      count_r <= count_nxt;
    end
  end

  // Count within capacity
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_FULL)
    else $error("element count above capacity");

  // Empty ring has both ends at the same slot
  a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (front_r == back_r))
    else $error("empty ring with split pointers");

  // Full ring has both ends at the same slot as well
  a_full_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == CNT_FULL) |-> (front_r == back_r))
    else $error("full ring with split pointers");

endmodule

/* sv/circular_deque.sv */
// Double-ended queue of 32-bit signed values held in a ring RAM of DEPTH
// entries with one write port and one read port. Each input transfer carries one operation in
// in_tuser (push front, pop front, push back, pop back) and the value to push
// in in_tdata; each operation yields exactly one output transfer with the
// popped value, an empty flag, a dropped flag and the element count after the
// operation. A pop of an empty queue returns 0 with was_empty set; a push on a
// full queue overwrites the element at the far end and sets dropped, with the
// count held at DEPTH. The block takes one operation per cycle while the
// output side keeps up. A result is presented after its input transfer has
// passed the registered read of the ring RAM (the result stage) and then the
// output register. With the output stalled, one result waits in the result
// stage and one in the output register, and the input is held off until one
// of them moves. The RAM needs no clearing after reset: a pop only ever reads
// entries a push has written.
module circular_deque #(
  parameter int unsigned DEPTH  = cdq_pkg::DEPTH_DEF,
  parameter int unsigned AW     = $clog2(DEPTH),
  parameter int unsigned CW     = $clog2(DEPTH + 1),
  parameter int unsigned OUT_W  = ((cdq_pkg::DATA_W + 2 + CW + 7) / 8) * 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [cdq_pkg::DATA_W-1:0] in_tdata,   // [31:0] push_value
  input  logic [cdq_pkg::CMD_W-1:0]  in_tuser,   // [1:0] cmd
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [OUT_W-1:0]           out_tdata   // pop_value, was_empty, dropped,
                                                 // fill_count, zero fill
);
  import cdq_pkg::*;

  localparam int unsigned PAY_W = DATA_W + 2 + CW;

  logic              in_xfer;
  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [DATA_W-1:0] ram_wdata, ram_rdata;
  cdq_res_t          res;
  logic [CW-1:0]     count_nxt;

  // Result stage: holds the operation's status while the RAM read data arrives
  logic              pend_r;
  cdq_res_t          pend_res_r;
  logic [CW-1:0]     pend_cnt_r;
  logic              pend_mv;

  // Output register
  logic              out_valid_r, out_valid_nxt;
  logic [PAY_W-1:0]  out_pay_r;
  logic [DATA_W-1:0] pop_value;

  // Advance the result stage whenever the output register is free or draining
  assign pend_mv   = pend_r && (!out_valid_r || out_tready);
  assign in_tready = !pend_r || pend_mv;
  assign in_xfer   = in_tvalid && in_tready;

  cdq_ctrl #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (in_xfer),
    .cmd        (cdq_cmd_t'(in_tuser)),
    .push_value (in_tdata),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_re     (ram_re),
    .ram_raddr  (ram_raddr),
    .res        (res),
    .count_nxt  (count_nxt)
  );

  cdq_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Hold the status of the accepted operation until its read data lands
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
    end else if (in_xfer) begin
      pend_r <= 1'b1;
    end else if (pend_mv) begin
      pend_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      pend_res_r <= res;
      pend_cnt_r <= count_nxt;
    end
  end

  // Read data stays put while pending: no new read is issued until it moves
  assign pop_value     = pend_res_r.rd ? ram_rdata : '0;
  assign out_valid_nxt = pend_mv || (out_valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pend_mv) begin
      out_pay_r <= {pend_cnt_r, pend_res_r.dropped, pend_res_r.empty, pop_value};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'(out_pay_r);

  // An input transfer always leaves a result pending in the next cycle
  a_accept_pends: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> pend_r)
    else $error("accepted operation lost before result stage");

  // A blocked result stays pending
  a_pend_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_r && !pend_mv) |=> pend_r)
    else $error("pending result dropped while output blocked");

  // Empty pops and drops exclude each other, and an empty pop reads nothing
  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> !(pend_res_r.empty && (pend_res_r.dropped || pend_res_r.rd)))
    else $error("inconsistent result flags");

  // Reported count within capacity
  a_out_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_pay_r[PAY_W-1 -: CW] <= CW'(DEPTH)))
    else $error("reported count above capacity");

endmodule

/* sim/circular_deque_test.sv */
`timescale 1ns / 100ps

module circular_deque_test;
  import cdq_pkg::*;

  localparam int unsigned DEPTH = DEPTH_DEF;
  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned OUT_W = ((DATA_W + 2 + CNT_W + 7) / 8) * 8;
  localparam int unsigned QUIET_LIMIT = 2000;  // cycles with no transfer on either side
  localparam int unsigned SETTLE_CYCLES = 8;   // extra cycles after the drain before the final check
  localparam int unsigned MAX_REPORTS = 10;

  // One operation waiting to be driven; hold_for_drain makes the sender wait
  // until every outstanding result has come back before presenting it.
  typedef struct {
    cdq_cmd_t          op;
    logic [DATA_W-1:0] value;
    bit                hold_for_drain;
  } deque_op_t;

  typedef struct packed {
    logic [DATA_W-1:0] pop_value;
    logic              was_empty;
    logic              dropped;
    logic [CNT_W-1:0]  fill_count;
  } deque_result_t;

  logic                clk;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [DATA_W-1:0]   in_tdata;   // [31:0] push_value
  logic [CMD_W-1:0]    in_tuser;   // [1:0] cmd
  logic                out_tvalid;
  logic                out_tready;
  logic [OUT_W-1:0]    out_tdata;  // [31:0] pop_value, [32] was_empty, [33] dropped,
                                   // [44:34] fill_count, zero fill above

  circular_deque dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #5 clk = ~clk;

  deque_op_t     pending_ops[$];
  deque_result_t expected_results[$];
  int unsigned   total_ops;
  int unsigned   sent_count;
  int unsigned   mismatch_count;
  int            gen_fill;       // element count as the generator sees it
  bit            in_took;        // input transfer at the last rising edge

  // Predicted deque: ring contents, front and back pointers, element count
  logic [DATA_W-1:0] ring [DEPTH];
  logic [IDX_W-1:0]  head_idx;
  logic [IDX_W-1:0]  tail_idx;
  logic [CNT_W-1:0]  fill;

  function automatic logic [IDX_W-1:0] step_up(logic [IDX_W-1:0] i);
    return (i == IDX_W'(DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [IDX_W-1:0] step_down(logic [IDX_W-1:0] i);
    return (i == '0) ? IDX_W'(DEPTH - 1) : i - 1'b1;
  endfunction

  // Apply one operation to the predicted deque and return its result
  function automatic deque_result_t deque_apply(cdq_cmd_t op, logic [DATA_W-1:0] value);
    deque_result_t r;
    r = '0;
    case (op)
      CMD_PUSH_FRONT: begin
        head_idx = step_down(head_idx);
        ring[head_idx] = value;
        // full: the back element falls off
        if (fill == CNT_W'(DEPTH)) begin
          tail_idx = step_down(tail_idx);
          r.dropped = 1'b1;
        end else begin
          fill = fill + 1'b1;
        end
      end
      CMD_POP_FRONT: begin
        if (fill == '0) begin
          r.was_empty = 1'b1;
        end else begin
          r.pop_value = ring[head_idx];
          head_idx = step_up(head_idx);
          fill = fill - 1'b1;
        end
      end
      CMD_PUSH_BACK: begin
        ring[tail_idx] = value;
        tail_idx = step_up(tail_idx);
        // full: the front element is overwritten
        if (fill == CNT_W'(DEPTH)) begin
          head_idx = step_up(head_idx);
          r.dropped = 1'b1;
        end else begin
          fill = fill + 1'b1;
        end
      end
      default: begin
        if (fill == '0) begin
          r.was_empty = 1'b1;
        end else begin
          tail_idx = step_down(tail_idx);
          r.pop_value = ring[tail_idx];
          fill = fill - 1'b1;
        end
      end
    endcase
    r.fill_count = fill;
    return r;
  endfunction

  // Queue one operation and track the element count for shaping the sequence
  task automatic queue_op(cdq_cmd_t op, logic [DATA_W-1:0] value, bit hold);
    deque_op_t item;
    item.op = op;
    item.value = value;
    item.hold_for_drain = hold;
    pending_ops.push_back(item);
    if (op == CMD_PUSH_FRONT || op == CMD_PUSH_BACK) begin
      if (gen_fill < int'(DEPTH)) gen_fill++;
    end else if (gen_fill > 0) begin
      gen_fill--;
    end
  endtask

  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic cdq_cmd_t pick_push();
    return $urandom_range(1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
  endfunction

  function automatic cdq_cmd_t pick_pop();
    return $urandom_range(1) ? CMD_POP_BACK : CMD_POP_FRONT;
  endfunction

  // Occasionally make the sender wait for every result before going on
  function automatic bit roll_hold();
    return $urandom_range(149) == 0;
  endfunction

  // Sender: present the next operation at the falling edge once the previous
  // one has transferred; idle and stall rates follow the phase of the run.
  int unsigned run_phase;
  int unsigned send_idle_pct;
  int unsigned stall_pct;
  deque_op_t   next_op;

  always @(negedge clk) begin
    if (rst_n) begin
      run_phase = (sent_count * 4) / total_ops;
      send_idle_pct = (run_phase == 1) ? 45 : (run_phase == 3) ? 16 : 0;
      stall_pct = (run_phase == 2) ? 45 : (run_phase == 3) ? 16 : 0;
      if (!in_tvalid || in_took) begin
        if (pending_ops.size() != 0 &&
            !(pending_ops[0].hold_for_drain && expected_results.size() != 0) &&
            $urandom_range(99) >= send_idle_pct) begin
          next_op = pending_ops.pop_front();
          in_tvalid <= 1'b1;
          in_tuser <= next_op.op;
          in_tdata <= next_op.value;
          sent_count++;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Monitor: predict on every input transfer, check every output transfer
  deque_result_t want;
  deque_result_t got;

  always @(posedge clk) begin
    in_took = rst_n && in_tvalid && in_tready;
    if (in_took) begin
      expected_results.push_back(deque_apply(cdq_cmd_t'(in_tuser), in_tdata));
    end
    if (rst_n && out_tvalid && out_tready) begin
      got.pop_value = out_tdata[DATA_W-1:0];
      got.was_empty = out_tdata[DATA_W];
      got.dropped = out_tdata[DATA_W+1];
      got.fill_count = out_tdata[DATA_W+2 +: CNT_W];
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
          $display("%0t: result with nothing expected: pop_value=%0d was_empty=%0b",
                   $realtime, $signed(got.pop_value), got.was_empty);
        end
      end else begin
        want = expected_results.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("%0t: expected pop_value=%0d was_empty=%0b dropped=%0b fill_count=%0d",
                     $realtime, $signed(want.pop_value), want.was_empty, want.dropped,
                     want.fill_count);
            $display("%0t: actual   pop_value=%0d was_empty=%0b dropped=%0b fill_count=%0d",
                     $realtime, $signed(got.pop_value), got.was_empty, got.dropped,
                     got.fill_count);
          end
        end
      end
    end
  end

  // Watchdog: give up once neither side has transferred for too long
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet = 0;
      else quiet++;
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    int unsigned n;
    clk = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = CMD_PUSH_FRONT;
    out_tready = 1'b0;
    in_took = 1'b0;
    sent_count = 0;
    mismatch_count = 0;
    gen_fill = 0;
    head_idx = '0;
    tail_idx = '0;
    fill = '0;

    // Directed: pops on an empty deque, extreme values at both ends, a
    // front push that wraps the pointer below zero, alternating bit patterns
    queue_op(CMD_POP_FRONT, 32'hDEAD_BEEF, 1'b0);
    queue_op(CMD_POP_BACK, 32'h0123_4567, 1'b0);
    queue_op(CMD_PUSH_FRONT, 32'h7FFF_FFFF, 1'b0);
    queue_op(CMD_PUSH_BACK, 32'h8000_0000, 1'b0);
    queue_op(CMD_PUSH_FRONT, 32'hFFFF_FFFF, 1'b0);
    queue_op(CMD_PUSH_BACK, 32'h0000_0000, 1'b0);
    queue_op(CMD_POP_BACK, 32'hFFFF_FFFF, 1'b0);
    queue_op(CMD_POP_FRONT, 32'h0000_0000, 1'b0);
    queue_op(CMD_POP_FRONT, 32'hAAAA_AAAA, 1'b0);
    queue_op(CMD_POP_BACK, 32'h5555_5555, 1'b0);
    queue_op(CMD_POP_BACK, 32'h0000_0000, 1'b0);
    queue_op(CMD_PUSH_BACK, 32'hAAAA_AAAA, 1'b0);
    queue_op(CMD_PUSH_BACK, 32'h5555_5555, 1'b1);
    queue_op(CMD_POP_FRONT, 32'h0000_0000, 1'b0);
    queue_op(CMD_POP_FRONT, 32'h0000_0000, 1'b0);
    queue_op(CMD_POP_FRONT, 32'h0000_0000, 1'b0);
    queue_op(CMD_PUSH_FRONT, 32'h0000_0001, 1'b0);
    queue_op(CMD_PUSH_FRONT, 32'hFFFF_FFFE, 1'b0);
    queue_op(CMD_POP_BACK, 32'h0000_0000, 1'b0);
    queue_op(CMD_POP_BACK, 32'h0000_0000, 1'b0);
    queue_op(CMD_POP_FRONT, 32'hFFFF_FFFF, 1'b0);

    // Shallow random walk: every operation, frequent pops on empty
    queue_op(pick_pop(), $urandom, 1'b1);
    for (n = 0; n < 20; n++) begin
      queue_op(cdq_cmd_t'($urandom_range(3)), pick_value(), roll_hold());
    end

    // Fill to capacity with pushes at random ends
    while (gen_fill < int'(DEPTH)) begin
      queue_op(pick_push(), pick_value(), roll_hold());
    end

    // Push past full at both ends so elements drop off either side
    for (n = 0; n < 12; n++) begin
      queue_op(pick_push(), pick_value(), roll_hold());
    end

    // Hover around full
    for (n = 0; n < 8; n++) begin
      if ($urandom_range(99) < 55) queue_op(pick_push(), pick_value(), roll_hold());
      else queue_op(pick_pop(), $urandom, roll_hold());
    end
    total_ops = pending_ops.size();

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Drain: wait for every operation and result, then let the pipe settle
    while (pending_ops.size() != 0 || in_tvalid || expected_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/cdq_pkg.sv
sv/cdq_ram.sv
sv/cdq_ctrl.sv
sv/circular_deque.sv
sim/circular_deque_test.sv
